### src/timed_pose_interpolator_defines.svh
// Assertion macros of the timed pose interpolator, used by the controller.
`ifndef TIMED_POSE_INTERPOLATOR_DEFINES_SVH
`define TIMED_POSE_INTERPOLATOR_DEFINES_SVH
`ifndef SYNTH
`define TPI_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define TPI_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`else
`define TPI_ASSERT(label, clk, rst_n, prop)
`define TPI_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### src/tpi_pkg.sv
// Package with shared types and constants of the timed pose interpolator.
package tpi_pkg;
	localparam int MAX_POSES = 1024;
	localparam int MATRIX_ENTRIES = 16;
	localparam int SLOT_W = $clog2(MAX_POSES);
	localparam int ENT_W = $clog2(MATRIX_ENTRIES);
	localparam int CNT_W = SLOT_W + 1;
	localparam int TIME_W = 40;
	localparam int VAL_W = 32;
	localparam int T_W = 24;
	localparam logic [TIME_W-1:0] MAX_DIFF_RESET = 40'd100000;
	localparam logic [CNT_W-1:0] POSE_COUNT_RESET = CNT_W'(2);
	localparam logic CFG_MAX_DIFF = 1'b0;
	localparam logic CFG_POSE_COUNT = 1'b1;
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic load;
		logic srch_init;
		logic srch_rd;
		logic srch_step;
		logic brk_rd0;
		logic brk_rd1;
		logic brk_cap0;
		logic brk_cap1;
		logic div_start;
		logic ent_rd;
		logic ent_cap;
		logic blend_go;
	} cmd_t;

	typedef struct packed {
		logic srch_done;
		logic too_far;
		logic div_done;
		logic ent_last;
	} stat_t;
endpackage

### src/timed_pose_interpolator.sv
// Top level of the timed pose interpolator.
//  channel  | handshake             | payload
//  command  | start, busy           | op, pose_index, entry_index, pose_time, entry_value,
//           |                       | frame_time
//  config   | cfg_valid, cfg_ready  | cfg_index, cfg_data
//  result   | result_valid strobe   | dropped, out_entry_index, out_entry_value, last
// A load never raises busy.
// A query runs the search and bracket reads, with at most floor(log2(n))+1 halving steps for
// the pose count n clamped to 2..1024, then the serial divider, then each entry in turn through
// the shared entry memory port.
// A dropped query ends after the bracket check with one result.
// Reset is asynchronous and clears only control and configuration state; the pose memories hold no reset value.
// Results are strobes; the receiver cannot stall them.
module timed_pose_interpolator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 op,
	input  logic [9:0]                           pose_index,
	input  logic [3:0]                           entry_index,
	input  logic [39:0]                          pose_time,
	input  logic signed [31:0]                   entry_value,
	input  logic [39:0]                          frame_time,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 cfg_index,
	input  logic [39:0]                          cfg_data,
	output logic                                 result_valid,
	output logic                                 dropped,
	output logic [3:0]                           out_entry_index,
	output logic signed [31:0]                   out_entry_value,
	output logic                                 last
);
	tpi_pkg::cmd_t  cmd;
	tpi_pkg::stat_t stat;
	logic [39:0] max_diff_q;
	logic [10:0] pose_count_q;
	logic [3:0]  res_index;
	logic signed [31:0] res_value;
	logic res_drop;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_diff_q <= tpi_pkg::MAX_DIFF_RESET;
			pose_count_q <= tpi_pkg::POSE_COUNT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == tpi_pkg::CFG_MAX_DIFF) begin
				max_diff_q <= cfg_data;
			end else begin
				pose_count_q <= cfg_data[10:0];
			end
		end
	end

	tpi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(op), .busy(busy),
		.cmd(cmd), .stat(stat), .res_valid(result_valid), .res_drop(res_drop),
		.res_last(last)
	);

	tpi_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.pose_index(pose_index), .entry_index(entry_index), .pose_time(pose_time),
		.entry_value(entry_value), .frame_time(frame_time), .max_diff(max_diff_q),
		.pose_count(pose_count_q), .res_index(res_index), .res_value(res_value)
	);

	assign dropped = res_drop;
	assign out_entry_index = res_drop ? 4'd0 : res_index;
	assign out_entry_value = res_drop ? 32'sd0 : res_value;
endmodule

### src/tpi_ram.sv
// Generic single-port RAM with registered read.
module tpi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### src/tpi_div.sv
// Restoring divider that forms the rounded Q8.16 time fraction, one bit a cycle.
module tpi_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [tpi_pkg::TIME_W:0]  num,
	input  logic [tpi_pkg::TIME_W:0]  den,
	output logic                      done,
	output logic signed [tpi_pkg::T_W-1:0] frac
);
	localparam int QW = 26;
	logic [tpi_pkg::TIME_W+1:0] rem_q;
	logic [tpi_pkg::TIME_W:0]   div_q;
	logic [tpi_pkg::TIME_W+16:0] sh_q;
	logic [QW-1:0]              quo_q;
	logic [5:0]                 cnt_q;
	logic                       busy_q, neg_q, zero_q, ovf_q;
	logic [tpi_pkg::TIME_W:0]   un, ud;
	logic [tpi_pkg::TIME_W+1:0] trial;
	logic [QW:0]                q_rnd;
	logic [tpi_pkg::TIME_W+1:0] rem_x2;

	assign un = num[tpi_pkg::TIME_W] ? (~num + 1'b1) : num;
	assign ud = den[tpi_pkg::TIME_W] ? (~den + 1'b1) : den;
	assign trial = {rem_q[tpi_pkg::TIME_W:0], sh_q[tpi_pkg::TIME_W+16]};
	assign rem_x2 = {rem_q[tpi_pkg::TIME_W:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd57;
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q <= {un, 16'd0};
			div_q <= ud;
			quo_q <= '0;
			ovf_q <= 1'b0;
			neg_q <= num[tpi_pkg::TIME_W] ^ den[tpi_pkg::TIME_W];
			zero_q <= (den == '0);
		end else if (busy_q && cnt_q != 6'd0) begin
			sh_q <= {sh_q[tpi_pkg::TIME_W+15:0], 1'b0};
			ovf_q <= ovf_q | quo_q[QW-1];
			if (trial >= {1'b0, div_q}) begin
				rem_q <= trial - {1'b0, div_q};
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

	// Rounding: add one when twice the remainder reaches the divisor.
	assign q_rnd = {1'b0, quo_q} + {{QW{1'b0}}, rem_x2 >= {1'b0, div_q}};

	always_comb begin
		if (zero_q) begin
			frac = '0;
		end else if (neg_q) begin
			frac = (ovf_q || q_rnd > {1'b0, QW'(8388608)}) ? 24'sh800000 :
				-$signed(q_rnd[23:0]);
		end else begin
			frac = (ovf_q || q_rnd > {1'b0, QW'(8388607)}) ? 24'sh7fffff :
				$signed(q_rnd[23:0]);
		end
	end
endmodule

### src/tpi_datapath.sv
// Datapath: pose stores, search registers, bracket check and entry blending.
module tpi_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tpi_pkg::cmd_t                 cmd,
	output tpi_pkg::stat_t                stat,
	input  logic [tpi_pkg::SLOT_W-1:0]    pose_index,
	input  logic [tpi_pkg::ENT_W-1:0]     entry_index,
	input  logic [tpi_pkg::TIME_W-1:0]    pose_time,
	input  logic signed [tpi_pkg::VAL_W-1:0] entry_value,
	input  logic [tpi_pkg::TIME_W-1:0]    frame_time,
	input  logic [tpi_pkg::TIME_W-1:0]    max_diff,
	input  logic [tpi_pkg::CNT_W-1:0]     pose_count,
	output logic [tpi_pkg::ENT_W-1:0]     res_index,
	output logic signed [tpi_pkg::VAL_W-1:0] res_value
);
	localparam int SW = tpi_pkg::SLOT_W;
	localparam int CW = tpi_pkg::CNT_W;
	localparam int TW = tpi_pkg::TIME_W;

	logic [TW-1:0] ft_q, t0_q, t1_q;
	logic [CW-1:0] lo_q, len_q, n_q, half, mid, i0w;
	logic [SW-1:0] i0_q, i0n, taddr, eslot;
	logic [tpi_pkg::ENT_W-1:0] k_q, ek_q;
	logic [TW-1:0] trd;
	logic signed [tpi_pkg::VAL_W-1:0] erd, a_q;
	logic [SW+tpi_pkg::ENT_W-1:0] eaddr;
	logic [CW-1:0] nclamp;
	logic div_done;
	logic signed [tpi_pkg::T_W-1:0] frac, t_q;
	logic [TW-1:0] d0, d1;
	logic signed [57:0] p1_s1, p2_s1;
	logic signed [58:0] v;
	logic [58:0] mag;
	logic [42:0] r;
	logic signed [tpi_pkg::VAL_W-1:0] sat;
	logic signed [25:0] omt;

	assign nclamp = (pose_count < CW'(2)) ? CW'(2) :
		(pose_count > CW'(tpi_pkg::MAX_POSES) ? CW'(tpi_pkg::MAX_POSES) : pose_count);
	assign half = len_q >> 1;
	assign mid = lo_q + half;
	assign i0w = (lo_q != '0) ? lo_q - 1'b1 : '0;
	assign i0n = (i0w >= n_q - 1'b1) ? SW'(n_q - CW'(2)) : i0w[SW-1:0];

	always_comb begin
		taddr = cmd.load ? pose_index : mid[SW-1:0];
		if (cmd.brk_rd0) begin
			taddr = i0n;
		end else if (cmd.brk_rd1) begin
			taddr = i0_q + 1'b1;
		end
	end

	tpi_ram #(.WIDTH(TW), .DEPTH(tpi_pkg::MAX_POSES)) u_time (
		.clk(clk), .we(cmd.load), .addr(taddr), .wdata(pose_time), .rdata(trd)
	);

	assign eslot = cmd.load ? pose_index : (ek_q[0] ? i0_q + 1'b1 : i0_q);
	assign eaddr = cmd.load ? {pose_index, entry_index} : {eslot, k_q};
	tpi_ram #(.WIDTH(tpi_pkg::VAL_W), .DEPTH(tpi_pkg::MAX_POSES * tpi_pkg::MATRIX_ENTRIES))
	u_entry (
		.clk(clk), .we(cmd.load), .addr(eaddr), .wdata(entry_value), .rdata(erd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			ek_q <= '0;
		end else begin
			if (cmd.srch_init) begin
				k_q <= '0;
				ek_q <= '0;
			end else if (cmd.ent_rd) begin
				ek_q[0] <= ~ek_q[0];
			end else if (cmd.blend_go) begin
				k_q <= k_q + 1'b1;
				ek_q[0] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.srch_init) begin
			ft_q <= frame_time;
			lo_q <= '0;
			len_q <= nclamp;
			n_q <= nclamp;
		end else if (cmd.srch_step) begin
			if (trd < ft_q) begin
				lo_q <= mid + 1'b1;
				len_q <= len_q - half - 1'b1;
			end else begin
				len_q <= half;
			end
		end
		if (cmd.brk_rd0) begin
			i0_q <= i0n;
		end
		if (cmd.brk_cap0) t0_q <= trd;
		if (cmd.brk_cap1) t1_q <= trd;
		if (div_done) t_q <= frac;
		if (cmd.ent_cap) a_q <= erd;
	end

	assign d0 = (ft_q > t0_q) ? ft_q - t0_q : t0_q - ft_q;
	assign d1 = (ft_q > t1_q) ? ft_q - t1_q : t1_q - ft_q;
	assign stat.too_far = (d0 > max_diff) || (d1 > max_diff);
	assign stat.srch_done = (len_q == '0);
	assign stat.div_done = div_done;
	assign stat.ent_last = (k_q == tpi_pkg::ENT_W'(tpi_pkg::MATRIX_ENTRIES - 1));

	tpi_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num({1'b0, ft_q} - {1'b0, t0_q}),
		.den({1'b0, t1_q} - {1'b0, t0_q}),
		.done(div_done), .frac(frac)
	);

	assign omt = 26'sd65536 - 26'(t_q);
	always_ff @(posedge clk) begin
		if (cmd.blend_go) begin
			p1_s1 <= omt * a_q;
			p2_s1 <= t_q * erd;
		end
	end

	assign v = 59'(p1_s1) + 59'(p2_s1);
	assign mag = v[58] ? -v : v;
	assign r = 43'((mag + 59'd32768) >> 16);
	assign sat = v[58] ? ((r > 43'd2147483648) ? 32'sh80000000 : -$signed(r[31:0])) :
		((r > 43'd2147483647) ? 32'sh7fffffff : $signed(r[31:0]));

	always_ff @(posedge clk) begin
		res_index <= k_q - 1'b1;
		res_value <= sat;
	end
endmodule

### src/tpi_ctrl.sv
// Controller state machine that sequences load, search, division and blending.
`include "timed_pose_interpolator_defines.svh"
module tpi_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           op,
	output logic           busy,
	output tpi_pkg::cmd_t  cmd,
	input  tpi_pkg::stat_t stat,
	output logic           res_valid,
	output logic           res_drop,
	output logic           res_last
);
	typedef enum logic [3:0] {
		S_IDLE, S_SRD, S_SSTEP, S_BRD0, S_BRD1, S_BCAP0, S_BCAP1, S_CHECK,
		S_DIV, S_ERDA, S_ERDB, S_BLEND, S_OUT
	} state_t;

	state_t state_q;
	logic   last_q;

	always_comb begin
		cmd = '0;
		cmd.load = start && !busy && op == tpi_pkg::OP_LOAD;
		cmd.srch_init = start && !busy && op == tpi_pkg::OP_QUERY;
		case (state_q)
			S_SRD: cmd.srch_rd = 1'b1;
			S_SSTEP: cmd.srch_step = 1'b1;
			S_BRD0: cmd.brk_rd0 = 1'b1;
			S_BRD1: begin
				cmd.brk_rd1 = 1'b1;
				cmd.brk_cap0 = 1'b1;
			end
			S_BCAP0: cmd.brk_cap1 = 1'b1;
			S_CHECK: cmd.div_start = !stat.too_far;
			S_ERDA: cmd.ent_rd = 1'b1;
			S_ERDB: begin
				cmd.ent_rd = 1'b1;
				cmd.ent_cap = 1'b1;
			end
			S_BLEND: cmd.blend_go = 1'b1;
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_valid <= 1'b0;
			res_drop <= 1'b0;
			res_last <= 1'b0;
			last_q <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			res_drop <= 1'b0;
			res_last <= 1'b0;
			case (state_q)
				S_IDLE: if (cmd.srch_init) state_q <= S_SRD;
				S_SRD: state_q <= stat.srch_done ? S_BRD0 : S_SSTEP;
				S_SSTEP: state_q <= S_SRD;
				S_BRD0: state_q <= S_BRD1;
				S_BRD1: state_q <= S_BCAP0;
				S_BCAP0: state_q <= S_BCAP1;
				S_BCAP1: state_q <= S_CHECK;
				S_CHECK: begin
					if (stat.too_far) begin
						res_valid <= 1'b1;
						res_drop <= 1'b1;
						res_last <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: if (stat.div_done) state_q <= S_ERDA;
				S_ERDA: state_q <= S_ERDB;
				S_ERDB: state_q <= S_BLEND;
				S_BLEND: begin
					last_q <= stat.ent_last;
					state_q <= S_OUT;
				end
				S_OUT: begin
					state_q <= last_q ? S_IDLE : S_ERDA;
				end
				default: state_q <= S_IDLE;
			endcase
			if (state_q == S_OUT) begin
				res_valid <= 1'b1;
				res_last <= last_q;
			end
		end
	end

	`TPI_ASSERT_NEXT(a_load_idle, clk, arst_n, cmd.load, state_q == S_IDLE)
	`TPI_ASSERT(a_last_valid, clk, arst_n, res_last |-> res_valid)
	`TPI_ASSERT(a_drop_last, clk, arst_n, res_drop |-> res_last)
endmodule

### tb/sv/timed_pose_interpolator_test.sv
// Self-checking testbench of the timed pose interpolator: directed table, then random phases.
module timed_pose_interpolator_test;
	localparam int LIMIT_CYCLES = 3000000;
	localparam int SETTLE_CYCLES = 200;
	localparam logic [39:0] TIME_MAX = 40'hFF_FFFF_FFFF;

	typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		int slot;
		int ent;
		logic [39:0] tval;
		logic [31:0] evalue;
		bit drop_typed;
	} dir_row_t;

	typedef struct {
		logic dropped;
		logic [3:0] idx;
		logic signed [31:0] value;
		logic last;
	} pose_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic op = tpi_pkg::OP_LOAD;
	logic [9:0] pose_index = '0;
	logic [3:0] entry_index = '0;
	logic [39:0] pose_time = '0;
	logic signed [31:0] entry_value = '0;
	logic [39:0] frame_time = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = tpi_pkg::CFG_MAX_DIFF;
	logic [39:0] cfg_data = '0;
	logic result_valid;
	logic dropped;
	logic [3:0] out_entry_index;
	logic signed [31:0] out_entry_value;
	logic last;

	timed_pose_interpolator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.pose_index(pose_index), .entry_index(entry_index), .pose_time(pose_time),
		.entry_value(entry_value), .frame_time(frame_time), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.result_valid(result_valid), .dropped(dropped), .out_entry_index(out_entry_index),
		.out_entry_value(out_entry_value), .last(last)
	);

	always #4 clk = ~clk;

	logic [39:0] model_max_diff = tpi_pkg::MAX_DIFF_RESET;
	logic [10:0] model_pose_count = tpi_pkg::POSE_COUNT_RESET;
	logic [39:0] slot_time [tpi_pkg::MAX_POSES];
	logic signed [31:0] slot_entry [tpi_pkg::MAX_POSES][tpi_pkg::MATRIX_ENTRIES];
	pose_result_t pending_entries [$];
	int errors = 0;
	int cycle_count = 0;
	int burst_left = 0;
	int slots_loaded = 0;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		pose_result_t exp_r;
		if (arst_n && result_valid) begin
			if (pending_entries.size() == 0) begin
				$error("result with no expectation waiting");
				errors++;
			end else begin
				exp_r = pending_entries.pop_front();
				if (dropped !== exp_r.dropped) begin
					$error("dropped: expected %0d, actual %0d", exp_r.dropped, dropped);
					errors++;
				end
				if (out_entry_index !== exp_r.idx) begin
					$error("out_entry_index: expected %0d, actual %0d", exp_r.idx,
						out_entry_index);
					errors++;
				end
				if (out_entry_value !== exp_r.value) begin
					$error("out_entry_value: expected %0d, actual %0d", exp_r.value,
						out_entry_value);
					errors++;
				end
				if (last !== exp_r.last) begin
					$error("last: expected %0d, actual %0d", exp_r.last, last);
					errors++;
				end
			end
		end
	end

	function automatic void expect_result(pose_result_t r);
		pending_entries = {pending_entries, r};
	endfunction

	function automatic longint time_fraction(longint num, longint den);
		bit neg;
		longint unsigned un, ud, q;
		neg = (num < 0) != (den < 0);
		un = (num < 0) ? -num : num;
		ud = (den < 0) ? -den : den;
		q = ((un << 16) + (ud >> 1)) / ud;
		if (neg)
			return (q > 64'd8388608) ? -64'sd8388608 : -longint'(q);
		return (q > 64'd8388607) ? 64'sd8388607 : longint'(q);
	endfunction

	function automatic logic signed [31:0] blend(logic signed [31:0] a, logic signed [31:0] b,
			longint t);
		longint v;
		longint unsigned mag, r;
		v = (65536 - t) * longint'(a) + t * longint'(b);
		mag = (v < 0) ? -v : v;
		r = (mag + 32768) >> 16;
		if (v < 0)
			return (r > 64'd2147483648) ? 32'sh8000_0000 : 32'(-longint'(r));
		return (r > 64'd2147483647) ? 32'sh7FFF_FFFF : 32'(r);
	endfunction

	function automatic void interpolate_frame(logic [39:0] ft);
		int n, lo, len, half, mid, i0;
		logic [39:0] t0, t1, d0, d1;
		longint t;
		pose_result_t r;
		n = model_pose_count;
		if (n < 2)
			n = 2;
		if (n > tpi_pkg::MAX_POSES)
			n = tpi_pkg::MAX_POSES;
		lo = 0;
		len = n;
		while (len > 0) begin
			half = len / 2;
			mid = lo + half;
			if (slot_time[mid] < ft) begin
				lo = mid + 1;
				len = len - half - 1;
			end else begin
				len = half;
			end
		end
		i0 = (lo != 0) ? lo - 1 : 0;
		if (i0 >= n - 1)
			i0 = n - 2;
		t0 = slot_time[i0];
		t1 = slot_time[i0 + 1];
		d0 = (ft > t0) ? ft - t0 : t0 - ft;
		d1 = (ft > t1) ? ft - t1 : t1 - ft;
		if (d0 > model_max_diff || d1 > model_max_diff) begin
			r = '{1'b1, 4'd0, 32'sd0, 1'b1};
			expect_result(r);
			return;
		end
		t = 0;
		if (t1 != t0)
			t = time_fraction(longint'({24'd0, ft}) - longint'({24'd0, t0}),
				longint'({24'd0, t1}) - longint'({24'd0, t0}));
		for (int k = 0; k < tpi_pkg::MATRIX_ENTRIES; k++) begin
			r.dropped = 1'b0;
			r.idx = 4'(k);
			r.value = blend(slot_entry[i0][k], slot_entry[i0 + 1][k], t);
			r.last = (k == tpi_pkg::MATRIX_ENTRIES - 1);
			expect_result(r);
		end
	endfunction

	task automatic send_command(logic cmd_op, int slot, int ent, logic [39:0] ptime,
			logic [31:0] evalue, logic [39:0] ftime, bit drop_typed);
		int gap;
		pose_result_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				start = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		start = 1'b1;
		op = cmd_op;
		pose_index = 10'(slot);
		entry_index = 4'(ent);
		pose_time = ptime;
		entry_value = evalue;
		frame_time = ftime;
		do @(posedge clk); while (busy);
		if (cmd_op == tpi_pkg::OP_LOAD) begin
			slot_time[slot] = ptime;
			slot_entry[slot][ent] = evalue;
		end else if (drop_typed) begin
			r = '{1'b1, 4'd0, 32'sd0, 1'b1};
			expect_result(r);
		end else begin
			interpolate_frame(ftime);
		end
	endtask

	task automatic write_register(logic idx, logic [39:0] data);
		@(negedge clk);
		start = 1'b0;
		while (pending_entries.size() != 0 || busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == tpi_pkg::CFG_MAX_DIFF)
			model_max_diff = data;
		else
			model_pose_count = data[10:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [39:0] rand_time();
		return {8'($urandom()), 32'($urandom())};
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($urandom_range(0, 131072)) - 32'd65536;
			default: return $urandom();
		endcase
	endfunction

	task automatic load_poses(int n, longint unsigned step_max, logic [39:0] base);
		logic [39:0] tcur;
		tcur = base;
		for (int s = 0; s < n; s++) begin
			if ($urandom_range(0, 9) == 0)
				tcur = rand_time();
			else if (s > 0)
				tcur = tcur + 40'($urandom() % (step_max + 1));
			if (s < slots_loaded)
				send_command(tpi_pkg::OP_LOAD, s, $urandom_range(0, 15), tcur,
					rand_value(), '0, 1'b0);
			else
				for (int e = 0; e < tpi_pkg::MATRIX_ENTRIES; e++)
					send_command(tpi_pkg::OP_LOAD, s, e, tcur, rand_value(), '0, 1'b0);
		end
		if (n > slots_loaded)
			slots_loaded = n;
	endtask

	task automatic run_queries(int n, int count, longint unsigned step_max);
		longint f;
		logic [39:0] ft;
		int j;
		for (int q = 0; q < count; q++) begin
			if ($urandom_range(0, 7) == 0) begin
				j = $urandom_range(0, n - 1);
				send_command(tpi_pkg::OP_LOAD, j, $urandom_range(0, 15),
					($urandom_range(0, 6) == 0) ? rand_time() : slot_time[j],
					rand_value(), '0, 1'b0);
			end
			j = $urandom_range(0, n - 1);
			case ($urandom_range(0, 9))
				0: ft = rand_time();
				1: ft = slot_time[j];
				default: begin
					f = longint'({24'd0, slot_time[j]})
						+ longint'($urandom() % (2 * step_max + 3)) - longint'(step_max) - 1;
					if (f < 0)
						f = 0;
					if (f > longint'({24'd0, TIME_MAX}))
						f = longint'({24'd0, TIME_MAX});
					ft = 40'(f);
				end
			endcase
			send_command(tpi_pkg::OP_QUERY, 0, 0, '0, '0, ft, 1'b0);
		end
	endtask

	dir_row_t dir_rows [22] = '{
		'{ROW_QUERY, 0, 0, 40'd0, 32'd0, 1'b0},
		'{ROW_QUERY, 0, 0, 40'd1000000, 32'd0, 1'b1},
		'{ROW_QUERY, 0, 0, 40'd1000, 32'd0, 1'b0},
		'{ROW_QUERY, 0, 0, 40'd1500, 32'd0, 1'b0},
		'{ROW_QUERY, 0, 0, 40'd2000, 32'd0, 1'b0},
		'{ROW_LOAD, 0, 0, 40'd1000, 32'h7FFF_FFFF, 1'b0},
		'{ROW_LOAD, 1, 0, 40'd2000, 32'h8000_0000, 1'b0},
		'{ROW_QUERY, 0, 0, 40'd1500, 32'd0, 1'b0},
		'{ROW_QUERY, 0, 0, 40'd2000, 32'd0, 1'b0},
		'{ROW_QUERY, 0, 0, 40'hFF_FFFF_FFFF, 32'd0, 1'b1},
		'{ROW_LOAD, 1, 5, 40'd1000, 32'd123, 1'b0},
		'{ROW_QUERY, 0, 0, 40'd1000, 32'd0, 1'b0},
		'{ROW_LOAD, 1, 5, 40'd1001, 32'hFFFF_FF85, 1'b0},
		'{ROW_QUERY, 0, 0, 40'd1200, 32'd0, 1'b0},
		'{ROW_CFG, 0, 0, 40'd0, 32'd0, 1'b0},
		'{ROW_QUERY, 0, 0, 40'd1001, 32'd0, 1'b1},
		'{ROW_CFG, 0, 0, 40'hFF_FFFF_FFFF, 32'd0, 1'b0},
		'{ROW_LOAD, 0, 3, 40'd5000, 32'h7FFF_FFFF, 1'b0},
		'{ROW_QUERY, 0, 0, 40'd3000, 32'd0, 1'b0},
		'{ROW_QUERY, 0, 0, 40'd0, 32'd0, 1'b0},
		'{ROW_CFG, 1, 0, 40'd0, 32'd0, 1'b0},
		'{ROW_QUERY, 0, 0, 40'd1001, 32'd0, 1'b0}
	};

	initial begin
		int pose_counts [8] = '{0, 2, 3, 5, 12, 1, 7, 9};
		longint unsigned steps [4] = '{1, 1000, 50000, 64'h4000_0000};
		longint unsigned step_max;
		logic [39:0] base, mtd;
		int n;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int s = 0; s < 2; s++)
			for (int e = 0; e < tpi_pkg::MATRIX_ENTRIES; e++)
				send_command(tpi_pkg::OP_LOAD, s, e, 40'(1000 * (s + 1)),
					32'(e * 65536 * (s ? -1 : 1)), '0, 1'b0);
		slots_loaded = 2;
		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_LOAD: send_command(tpi_pkg::OP_LOAD, dir_rows[i].slot, dir_rows[i].ent,
					dir_rows[i].tval, dir_rows[i].evalue, '0, 1'b0);
				ROW_QUERY: send_command(tpi_pkg::OP_QUERY, 0, 0, '0, '0, dir_rows[i].tval,
					dir_rows[i].drop_typed);
				default: write_register(dir_rows[i].slot[0], dir_rows[i].tval);
			endcase
		end
		foreach (pose_counts[p]) begin
			n = (pose_counts[p] < 2) ? 2 : pose_counts[p];
			step_max = steps[$urandom_range(0, 3)];
			base = ($urandom_range(0, 3) == 0) ? TIME_MAX - 40'(n * step_max) :
				40'($urandom_range(0, 100000));
			case ($urandom_range(0, 3))
				0: mtd = 40'($urandom() % (step_max + 1));
				1: mtd = TIME_MAX;
				2: mtd = 40'(2 * step_max);
				default: mtd = rand_time();
			endcase
			if (p == 0)
				mtd = '0;
			write_register(tpi_pkg::CFG_POSE_COUNT, 40'(pose_counts[p]));
			write_register(tpi_pkg::CFG_MAX_DIFF, mtd);
			load_poses(n, step_max, base);
			run_queries(n, 18, step_max);
		end
		@(negedge clk);
		start = 1'b0;
		while (pending_entries.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
